/* design/ppd_pkg.sv */
// Shared types, constants and header helpers for the port packet deframer.
// No dependencies; every other design file but ppd_ram refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ppd_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 516;
    localparam int NUM_NODES_DEF       = 16;
    localparam int SEQ_SLOTS           = 128;
    localparam int SEQ_ADDR_W          = 7;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [2:0] KIND_ACCEPT     = 3'd0;
    localparam logic [2:0] KIND_TOO_LONG   = 3'd1;
    localparam logic [2:0] KIND_BAD_SENDER = 3'd2;
    localparam logic [2:0] KIND_ODD_LENGTH = 3'd3;
    localparam logic [2:0] KIND_CORRUPTED  = 3'd4;

    localparam logic [15:0] SEQ_NONE   = 16'hFFFF;
    localparam logic [15:0] SEQ_WINDOW = 16'h0100;

    typedef struct packed {
        logic        req_type;
        logic [15:0] sender_id;
        logic [15:0] first_header;
        logic [15:0] frame_bytes;
        logic [7:0]  signal_strength;
        logic [15:0] data_word;
    } t_in;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [3:0]  port_number;
        logic [3:0]  source_id;
        logic [7:0]  strength_out;
        logic [8:0]  payload_word_offset;
        logic [9:0]  payload_bytes;
        logic [15:0] sequence_value;
    } t_out;

    // Payload length in bytes; a zero word count means 256 words.
    function automatic logic [9:0] hdr_len_bytes(input logic [15:0] h);
        logic [9:0] n;
        n = {1'b0, h[7:0], 1'b0};
        return (n == 10'd0) ? 10'd512 : n;
    endfunction

    // Payload plus sequence and destination footers.
    function automatic logic [9:0] hdr_total_bytes(input logic [15:0] h);
        logic [9:0] n;
        n = hdr_len_bytes(h);
        if (h[11]) n = n + 10'd2;
        if (h[12]) n = n + 10'd2;
        return n;
    endfunction

endpackage
`default_nettype wire

/* design/ppd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ppd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* design/ppd_front.sv */
// Front end: frame parser, sequence check and destination check.
// Depends on ppd_pkg and ppd_ram.
`timescale 1ns / 1ps
`default_nettype none
module ppd_front #(
    parameter int MAX_FRAME_BYTES = ppd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int NUM_NODES       = ppd_pkg::NUM_NODES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire ppd_pkg::t_in  i_item,
    input  wire logic [3:0]    i_own,
    output logic               o_res_valid,
    output ppd_pkg::t_out      o_res
);
    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_PAYLOAD, PH_SEQ, PH_DEST
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_br, n_br;
    logic [8:0]  r_wp, n_wp;
    logic [8:0]  r_pwl, n_pwl;
    logic [15:0] r_hdr, n_hdr;
    logic [15:0] r_capseq, n_capseq;
    logic        r_dropped, n_dropped;
    logic [3:0]  r_sender, n_sender;
    logic [7:0]  r_str, n_str;
    logic [ppd_pkg::SEQ_SLOTS-1:0] r_seq_vld;

    logic [ppd_pkg::SEQ_ADDR_W-1:0] w_slot;
    logic [15:0] w_rdata;
    logic        w_we;
    logic [15:0] w_wdata;

    assign w_slot = {r_sender, r_hdr[10:8]};

    ppd_ram #(.WIDTH(16), .DEPTH(ppd_pkg::SEQ_SLOTS)) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_slot),
        .i_wdata (w_wdata),
        .i_raddr (w_slot),
        .o_rdata (w_rdata)
    );

    always_comb begin
        logic        take;
        logic [15:0] th;
        logic [9:0]  tb;
        logic [9:0]  tot;
        logic        fin;
        logic        ok;
        logic [15:0] cur;
        logic [15:0] dbl;
        logic [15:0] diff;
        logic [8:0]  pwl_dec;
        logic [9:0]  r_tot;
        logic [9:0]  len_b;
        n_phase = r_phase; n_br = r_br; n_wp = r_wp; n_pwl = r_pwl; n_hdr = r_hdr;
        n_capseq = r_capseq; n_dropped = r_dropped; n_sender = r_sender; n_str = r_str;
        o_res_valid = 1'b0;
        o_res = '0;
        o_res.sequence_value = ppd_pkg::SEQ_NONE;
        w_we = 1'b0;
        take = 1'b0; th = '0; tb = '0; fin = 1'b0; ok = 1'b0;
        cur = r_seq_vld[w_slot] ? w_rdata : ppd_pkg::SEQ_NONE;
        dbl = {i_item.data_word[14:0], 1'b0};
        diff = cur - dbl;
        w_wdata = dbl;
        pwl_dec = (r_pwl != 9'd0) ? r_pwl - 9'd1 : 9'd0;
        r_tot = ppd_pkg::hdr_total_bytes(r_hdr);
        tot = '0;
        len_b = '0;
        if (i_valid) begin
            if (!i_item.req_type) begin
                n_phase = PH_IDLE;
                o_res.source_id = i_item.sender_id[3:0];
                o_res.strength_out = i_item.signal_strength;
                if (i_item.frame_bytes == 16'd0) begin
                    o_res_valid = 1'b0;
                end else if ({1'b0, i_item.frame_bytes} > 17'(MAX_FRAME_BYTES)) begin
                    o_res_valid = 1'b1;
                    o_res.result_kind = ppd_pkg::KIND_TOO_LONG;
                end else if (i_item.sender_id == {12'd0, i_own} ||
                             {1'b0, i_item.sender_id} >= 17'(NUM_NODES)) begin
                    o_res_valid = 1'b1;
                    o_res.result_kind = ppd_pkg::KIND_BAD_SENDER;
                end else if (i_item.frame_bytes[0]) begin
                    o_res_valid = 1'b1;
                    o_res.result_kind = ppd_pkg::KIND_ODD_LENGTH;
                end else begin
                    n_sender = i_item.sender_id[3:0];
                    n_str = i_item.signal_strength;
                    n_wp = '0;
                    take = 1'b1;
                    th = i_item.first_header;
                    tb = i_item.frame_bytes[9:0];
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_wp = r_wp + 9'd1;
                        if (r_br < 10'd2) begin
                            o_res_valid = 1'b1;
                            o_res.result_kind = ppd_pkg::KIND_CORRUPTED;
                            o_res.source_id = r_sender;
                            o_res.strength_out = r_str;
                            n_phase = PH_IDLE;
                        end else begin
                            take = 1'b1;
                            th = i_item.data_word;
                            tb = r_br - 10'd2;
                            n_br = tb;
                        end
                    end
                    PH_PAYLOAD: begin
                        n_wp = r_wp + 9'd1;
                        n_pwl = pwl_dec;
                        if (pwl_dec == 9'd0) begin
                            if (r_hdr[11]) n_phase = PH_SEQ;
                            else if (r_hdr[12]) n_phase = PH_DEST;
                            else begin fin = 1'b1; ok = 1'b1; end
                        end
                    end
                    PH_SEQ: begin
                        n_wp = r_wp + 9'd1;
                        if (cur[0]) begin
                            w_we = 1'b1;
                            n_capseq = i_item.data_word;
                        end else if (diff < ppd_pkg::SEQ_WINDOW) begin
                            n_dropped = 1'b1;
                        end else begin
                            w_we = 1'b1;
                            n_capseq = dbl;
                        end
                        if (r_hdr[12]) n_phase = PH_DEST;
                        else begin fin = 1'b1; ok = 1'b1; end
                    end
                    PH_DEST: begin
                        n_wp = r_wp + 9'd1;
                        fin = 1'b1;
                        ok = i_item.data_word[i_own];
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
            if (take) begin
                tot = ppd_pkg::hdr_total_bytes(th);
                len_b = ppd_pkg::hdr_len_bytes(th);
                if (tot > tb) begin
                    o_res_valid = 1'b1;
                    o_res.result_kind = ppd_pkg::KIND_CORRUPTED;
                    o_res.source_id = n_sender;
                    o_res.strength_out = n_str;
                    n_phase = PH_IDLE;
                end else begin
                    n_br = tb - tot;
                    n_hdr = th;
                    n_pwl = len_b[9:1];
                    n_capseq = ppd_pkg::SEQ_NONE;
                    n_dropped = 1'b0;
                    n_phase = PH_PAYLOAD;
                end
            end
            if (fin) begin
                if (!n_dropped && ok) begin
                    o_res_valid = 1'b1;
                    o_res.result_kind = ppd_pkg::KIND_ACCEPT;
                    o_res.port_number = r_hdr[11:8];
                    o_res.source_id = r_sender;
                    o_res.strength_out = r_str;
                    o_res.payload_word_offset = n_wp - r_tot[9:1];
                    o_res.payload_bytes = ppd_pkg::hdr_len_bytes(r_hdr);
                    o_res.sequence_value = n_capseq;
                end
                n_phase = (r_br != 10'd0) ? PH_HEADER : PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_br <= '0;
            r_wp <= '0;
            r_pwl <= '0;
            r_hdr <= '0;
            r_capseq <= ppd_pkg::SEQ_NONE;
            r_dropped <= 1'b0;
            r_sender <= '0;
            r_str <= '0;
            r_seq_vld <= '0;
        end else begin
            r_phase <= n_phase;
            r_br <= n_br;
            r_wp <= n_wp;
            r_pwl <= n_pwl;
            r_hdr <= n_hdr;
            r_capseq <= n_capseq;
            r_dropped <= n_dropped;
            r_sender <= n_sender;
            r_str <= n_str;
            if (w_we) r_seq_vld[w_slot] <= 1'b1;
        end
    end
endmodule
`default_nettype wire

/* design/ppd_queue.sv */
// Back end: result queue between the parser and the result channel.
// Depends on ppd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ppd_pkg::t_out i_data,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output ppd_pkg::t_out      o_data
);
    localparam int AW = $clog2(ppd_pkg::QUEUE_DEPTH);

    ppd_pkg::t_out r_q [ppd_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic          w_do_pop;

    assign o_full   = (r_cnt == (AW+1)'(ppd_pkg::QUEUE_DEPTH));
    assign o_empty  = (r_cnt == '0);
    assign o_data   = r_q[r_rd];
    assign w_do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (w_do_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(w_do_pop);
        end
    end
endmodule
`default_nettype wire

/* design/port_packet_deframer.sv */
// Port packet deframer: splits received multi-port frames into sub-packet
// descriptors. Depends on ppd_pkg, ppd_front, ppd_queue and ppd_ram.
//
// Input channel: queue-style, a beat is taken when i_push is high and o_full
// is low. A beat is either a frame start (header fields) or one data word.
// Result channel: the oldest descriptor sits on o_result while o_empty is low
// and leaves on a clock edge with i_pop high.
// Configuration: own node id written through i_cfg_we / i_cfg_data while idle.
//
// Throughput: one input beat per cycle while o_full is low; every beat is parsed in
// the cycle it is taken. The sequence check reads a 128-entry RAM whose
// address is fixed by the current header, so the read is issued ahead of the
// footer beat and adds no stall.
// A descriptor enters the queue on the clock edge that takes the beat that finishes it.
// Results pass through a four-deep queue; when the receiver stalls the queue
// fills and o_full holds the input side.
// Reset: parser idle, queue empty, every sequence slot unsynchronised (valid
// bits cleared at once, no clearing pass), own node id 0.
`timescale 1ns / 1ps
`default_nettype none
module port_packet_deframer #(
    parameter int MAX_FRAME_BYTES = ppd_pkg::MAX_FRAME_BYTES_DEF,
    parameter int NUM_NODES       = ppd_pkg::NUM_NODES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire ppd_pkg::t_in  i_item,
    output logic               o_empty,
    input  wire logic          i_pop,
    output ppd_pkg::t_out      o_result,
    input  wire logic          i_cfg_we,
    input  wire logic [3:0]    i_cfg_data
);
    logic [3:0]    r_own;
    logic          w_accept;
    logic          w_res_valid;
    ppd_pkg::t_out w_res;

    // Hold the own node id; the user must write it only between frames, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own <= '0;
        end else if (i_cfg_we) begin
            r_own <= i_cfg_data;
        end
    end

    // Take a beat only while the queue has room for its possible result.
    assign w_accept = i_push && !o_full;

    ppd_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .NUM_NODES       (NUM_NODES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_accept),
        .i_item      (i_item),
        .i_own       (r_own),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    ppd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .i_pop   (i_pop),
        .o_full  (o_full),
        .o_empty (o_empty),
        .o_data  (o_result)
    );

`ifndef ASSERT_OFF
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |=> !o_empty)
        else $error("result beat did not reach the queue");

    a_no_result_unaccepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |-> !w_res_valid)
        else $error("result produced without an accepted beat");

    a_reject_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.result_kind != ppd_pkg::KIND_ACCEPT) |->
        (o_result.payload_bytes == 10'd0 && o_result.port_number == 4'd0 &&
         o_result.sequence_value == ppd_pkg::SEQ_NONE))
        else $error("reject descriptor carries packet fields");
`endif
endmodule
`default_nettype wire

/* test/tb_port_packet_deframer.sv */
// Self-checking testbench for port_packet_deframer: queue-fed driver,
// randomly stalled receiver and a scoreboard fed by an in-bench predictor.
// Depends on ppd_pkg and the port_packet_deframer RTL only.
`timescale 1ns / 1ps
module tb_port_packet_deframer;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int LONG_STALL   = 400;
    localparam int PHASE_BEATS  = 330;

    typedef enum logic [2:0] {
        P_IDLE, P_HEADER, P_PAYLOAD, P_SEQ, P_DEST
    } t_parse;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic i_pop = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [3:0] i_cfg_data = 4'd0;
    ppd_pkg::t_in i_item = '0;
    logic o_full, o_empty;
    ppd_pkg::t_out o_result;

    port_packet_deframer DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full), .i_item(i_item),
        .o_empty(o_empty), .i_pop(i_pop), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // beats waiting to be offered, and descriptors the block still owes us
    ppd_pkg::t_in beats_q[$];
    ppd_pkg::t_out owed_results[$];

    int errors = 0;
    int cycles = 0;
    int beats_taken = 0;
    int results_seen = 0;
    int rejects_seen = 0;
    int gap_left = 0;
    int pop_gap = 0;
    int stall_left = 0;
    int stall_req = 0;
    int stall_done = 0;
    bit beat_taken = 1'b0;
    bit quiet_in = 1'b0;
    bit quiet_out = 1'b0;

    // predictor state
    logic [15:0] seq_slots[128];
    t_parse      phase;
    logic [15:0] bytes_left;
    logic [8:0]  word_pos;
    logic [8:0]  words_left;
    logic [15:0] cur_hdr;
    logic [15:0] cap_seq;
    bit          dropped;
    logic [3:0]  fsender;
    logic [7:0]  fstrength;
    logic [3:0]  own_id;

    function automatic logic [9:0] pay_bytes(input logic [15:0] h);
        return (h[7:0] == 8'd0) ? 10'd512 : {1'b0, h[7:0], 1'b0};
    endfunction

    function automatic logic [15:0] span_bytes(input logic [15:0] h);
        return {6'd0, pay_bytes(h)} + (h[11] ? 16'd2 : 16'd0) + (h[12] ? 16'd2 : 16'd0);
    endfunction

    task automatic owe(input logic [2:0] kind, input logic [3:0] port, input logic [3:0] src,
                       input logic [7:0] str, input logic [8:0] off, input logic [9:0] nb,
                       input logic [15:0] sq);
        ppd_pkg::t_out r;
        r.result_kind = kind;
        r.port_number = port;
        r.source_id = src;
        r.strength_out = str;
        r.payload_word_offset = off;
        r.payload_bytes = nb;
        r.sequence_value = sq;
        owed_results.push_back(r);
    endtask

    task automatic open_packet(input logic [15:0] h);
        logic [9:0] nb;
        nb = pay_bytes(h);
        if (span_bytes(h) > bytes_left) begin
            owe(ppd_pkg::KIND_CORRUPTED, 4'd0, fsender, fstrength, 9'd0, 10'd0,
                ppd_pkg::SEQ_NONE);
            phase = P_IDLE;
        end else begin
            bytes_left = bytes_left - span_bytes(h);
            cur_hdr = h;
            words_left = nb[9:1];
            cap_seq = ppd_pkg::SEQ_NONE;
            dropped = 1'b0;
            phase = P_PAYLOAD;
        end
    endtask

    task automatic close_packet(input bit dest_ok);
        logic [15:0] span;
        logic [8:0] off;
        span = span_bytes(cur_hdr);
        off = word_pos - span[9:1];
        if (!dropped && dest_ok)
            owe(ppd_pkg::KIND_ACCEPT, cur_hdr[11:8], fsender, fstrength, off,
                pay_bytes(cur_hdr), cap_seq);
        phase = (bytes_left != 16'd0) ? P_HEADER : P_IDLE;
    endtask

    // advance the predictor by one accepted beat
    task automatic deframe_beat(input ppd_pkg::t_in b);
        logic [6:0] slot;
        logic [15:0] entry, dbl, diff;
        if (!b.req_type) begin
            phase = P_IDLE;
            if (b.frame_bytes == 16'd0) begin
            end else if (b.frame_bytes > ppd_pkg::MAX_FRAME_BYTES_DEF) begin
                owe(ppd_pkg::KIND_TOO_LONG, 4'd0, b.sender_id[3:0], b.signal_strength,
                    9'd0, 10'd0, ppd_pkg::SEQ_NONE);
            end else if (b.sender_id == {12'd0, own_id} ||
                         b.sender_id >= ppd_pkg::NUM_NODES_DEF) begin
                owe(ppd_pkg::KIND_BAD_SENDER, 4'd0, b.sender_id[3:0], b.signal_strength,
                    9'd0, 10'd0, ppd_pkg::SEQ_NONE);
            end else if (b.frame_bytes[0]) begin
                owe(ppd_pkg::KIND_ODD_LENGTH, 4'd0, b.sender_id[3:0], b.signal_strength,
                    9'd0, 10'd0, ppd_pkg::SEQ_NONE);
            end else begin
                fsender = b.sender_id[3:0];
                fstrength = b.signal_strength;
                bytes_left = {6'd0, b.frame_bytes[9:0]};
                word_pos = 9'd0;
                open_packet(b.first_header);
            end
        end else begin
            case (phase)
                P_HEADER: begin
                    word_pos = word_pos + 9'd1;
                    if (bytes_left < 16'd2) begin
                        owe(ppd_pkg::KIND_CORRUPTED, 4'd0, fsender, fstrength, 9'd0, 10'd0,
                            ppd_pkg::SEQ_NONE);
                        phase = P_IDLE;
                    end else begin
                        bytes_left = bytes_left - 16'd2;
                        open_packet(b.data_word);
                    end
                end
                P_PAYLOAD: begin
                    word_pos = word_pos + 9'd1;
                    if (words_left != 9'd0) words_left = words_left - 9'd1;
                    if (words_left == 9'd0) begin
                        if (cur_hdr[11]) phase = P_SEQ;
                        else if (cur_hdr[12]) phase = P_DEST;
                        else close_packet(1'b1);
                    end
                end
                P_SEQ: begin
                    slot = {fsender, cur_hdr[10:8]};
                    entry = seq_slots[slot];
                    dbl = {b.data_word[14:0], 1'b0};
                    diff = entry - dbl;
                    word_pos = word_pos + 9'd1;
                    if (entry[0]) begin
                        seq_slots[slot] = dbl;
                        cap_seq = b.data_word;
                    end else if (diff < ppd_pkg::SEQ_WINDOW) begin
                        dropped = 1'b1;
                    end else begin
                        seq_slots[slot] = dbl;
                        cap_seq = dbl;
                    end
                    if (cur_hdr[12]) phase = P_DEST;
                    else close_packet(1'b1);
                end
                P_DEST: begin
                    word_pos = word_pos + 9'd1;
                    close_packet(b.data_word[own_id]);
                end
                default: begin
                    // stray word while idle: drop
                end
            endcase
        end
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
        errors++;
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic ppd_pkg::t_in random_beat();
        ppd_pkg::t_in b;
        b.req_type = 1'($urandom_range(0, 1));
        b.sender_id = 16'($urandom);
        b.first_header = 16'($urandom);
        b.frame_bytes = 16'($urandom);
        b.signal_strength = 8'($urandom);
        b.data_word = 16'($urandom);
        return b;
    endfunction

    function automatic ppd_pkg::t_in start_beat(input logic [15:0] sid,
                                                input logic [15:0] hdr,
                                                input logic [15:0] len,
                                                input logic [7:0] str);
        ppd_pkg::t_in b;
        b.req_type = 1'b0;
        b.sender_id = sid;
        b.first_header = hdr;
        b.frame_bytes = len;
        b.signal_strength = str;
        b.data_word = 16'($urandom_range(0, 65535));
        return b;
    endfunction

    function automatic ppd_pkg::t_in word_beat(input logic [15:0] w);
        ppd_pkg::t_in b;
        b = random_beat();
        b.req_type = 1'b1;
        b.data_word = w;
        return b;
    endfunction

    // queue one well-formed frame with random content; spoil it on request
    task automatic queue_frame(input bit spoil);
        logic [15:0] words[$];
        logic [15:0] sid, hdr, first, dest;
        int nbytes, npk, nw, k, i, r, cost;
        first = 16'd0;
        do sid = 16'($urandom_range(0, 15)); while (sid == {12'd0, own_id});
        npk = $urandom_range(1, 4);
        nbytes = 0;
        for (k = 0; k < npk; k++) begin
            r = $urandom_range(0, 99);
            nw = (r == 0) ? 0 : (r < 6) ? $urandom_range(20, 100) : $urandom_range(1, 6);
            hdr = 16'($urandom_range(0, 65535));
            hdr[7:0] = nw[7:0];
            if ($urandom_range(0, 9) < 7) hdr[10:9] = 2'd0;
            cost = span_bytes(hdr) + ((k > 0) ? 2 : 0);
            if (nbytes + cost > ppd_pkg::MAX_FRAME_BYTES_DEF) break;
            if (k > 0) words.push_back(hdr);
            else first = hdr;
            for (i = 0; i < pay_bytes(hdr) / 2; i++)
                words.push_back(16'($urandom_range(0, 65535)));
            if (hdr[11])
                words.push_back(16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                                : $urandom_range(0, 200)));
            if (hdr[12]) begin
                dest = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 4) != 0) dest[own_id] = 1'b1;
                words.push_back(dest);
            end
            nbytes += cost;
        end
        if (spoil) begin
            r = $urandom_range(0, 3);
            if (r == 0) nbytes += 2;
            else if (r == 1 && nbytes > 2) nbytes -= 2;
            else if (r == 2) words = words[0:$urandom_range(0, words.size()) - 1];
            else repeat ($urandom_range(1, 3)) words.push_back(16'($urandom_range(0, 65535)));
        end
        beats_q.push_back(start_beat(sid, first, 16'(nbytes), 8'($urandom_range(0, 255))));
        foreach (words[j]) beats_q.push_back(word_beat(words[j]));
    endtask

    task automatic queue_directed();
        ppd_pkg::t_in b;
        beats_q.push_back(word_beat(16'hFFFF));                            // stray word
        beats_q.push_back(start_beat(16'd3, 16'h0001, 16'd0, 8'h00));      // zero length
        beats_q.push_back(start_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF)); // too long
        beats_q.push_back(start_beat(16'd2, 16'h0001, 16'd517, 8'h11));
        beats_q.push_back(start_beat({12'd0, own_id}, 16'h0001, 16'd2, 8'h22)); // sender is us
        beats_q.push_back(start_beat(16'd16, 16'h0001, 16'd2, 8'h33));     // sender out of range
        beats_q.push_back(start_beat(16'd4, 16'h0001, 16'd3, 8'h44));      // odd length
        beats_q.push_back(start_beat(16'd5, 16'h000A, 16'd4, 8'h55));      // first packet overruns
        // second header overruns what is left
        beats_q.push_back(start_beat(16'd6, 16'h0301, 16'd6, 8'h66));
        beats_q.push_back(word_beat(16'h1234));
        beats_q.push_back(word_beat(16'h0005));
        // frame abandoned by a new start
        beats_q.push_back(start_beat(16'd7, 16'h0208, 16'd16, 8'h77));
        beats_q.push_back(word_beat(16'h0000));
        beats_q.push_back(word_beat(16'h0001));
        // both footers, destination bit clear, then the same sequence again
        b = start_beat(16'd9, 16'h1F01, 16'd14, 8'h88);
        beats_q.push_back(b);
        beats_q.push_back(word_beat(16'hAAAA));
        beats_q.push_back(word_beat(16'h0010));
        beats_q.push_back(word_beat(16'h0000));
        beats_q.push_back(word_beat(16'h1F01));
        beats_q.push_back(word_beat(16'h5555));
        beats_q.push_back(word_beat(16'h0010));
        beats_q.push_back(word_beat(16'hFFFF));
    endtask

    // driver: change inputs on the falling edge, hold the item until taken
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) quiet_in <= !quiet_in;
        if (i_push && !beat_taken) begin
            // hold the offered beat
        end else if (gap_left > 0) begin
            i_push <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (beats_q.size() > 0 && i_rst_n) begin
            i_item <= beats_q.pop_front();
            i_push <= 1'b1;
            gap_left <= pick_gap(quiet_in);
        end else begin
            i_push <= 1'b0;
        end
        beat_taken <= 1'b0;
    end

    // receiver: random pops, plus one long hold-off when asked
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) quiet_out <= !quiet_out;
        if (stall_req != stall_done) begin
            stall_done <= stall_req;
            stall_left <= LONG_STALL;
            i_pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_pop <= 1'b0;
        end else if (pop_gap > 0) begin
            pop_gap <= pop_gap - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= 1'b1;
            pop_gap <= pick_gap(quiet_out);
        end
    end

    // monitor: check the departing result first, then predict the arriving beat
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_port_packet_deframer NOT OK");
            $finish;
        end else if (i_rst_n) begin
            if (i_pop && !o_empty) begin
                results_seen++;
                if (o_result.result_kind != ppd_pkg::KIND_ACCEPT) rejects_seen++;
                if (owed_results.size() == 0) begin
                    report("unexpected result kind", 16'(o_result.result_kind), 16'd0);
                end else begin
                    ppd_pkg::t_out w;
                    w = owed_results.pop_front();
                    if (o_result.result_kind != w.result_kind)
                        report("result_kind", 16'(o_result.result_kind),
                               16'(w.result_kind));
                    if (o_result.port_number != w.port_number)
                        report("port_number", 16'(o_result.port_number),
                               16'(w.port_number));
                    if (o_result.source_id != w.source_id)
                        report("source_id", 16'(o_result.source_id), 16'(w.source_id));
                    if (o_result.strength_out != w.strength_out)
                        report("strength_out", 16'(o_result.strength_out),
                               16'(w.strength_out));
                    if (o_result.payload_word_offset != w.payload_word_offset)
                        report("payload_word_offset", 16'(o_result.payload_word_offset),
                               16'(w.payload_word_offset));
                    if (o_result.payload_bytes != w.payload_bytes)
                        report("payload_bytes", 16'(o_result.payload_bytes),
                               16'(w.payload_bytes));
                    if (o_result.sequence_value != w.sequence_value)
                        report("sequence_value", o_result.sequence_value, w.sequence_value);
                end
            end
            if (i_push && !o_full) begin
                deframe_beat(i_item);
                beat_taken <= 1'b1;
                beats_taken++;
            end
        end
    end

    task automatic drain();
        while (beats_q.size() > 0 || i_push || owed_results.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        logic [3:0] ids[5];
        int p, added, r;
        ids[0] = 4'd0;
        ids[1] = 4'd15;
        ids[2] = 4'($urandom_range(1, 14));
        ids[3] = 4'($urandom_range(0, 15));
        ids[4] = 4'd5;
        for (int i = 0; i < 128; i++) seq_slots[i] = ppd_pkg::SEQ_NONE;
        phase = P_IDLE;
        bytes_left = 16'd0;
        word_pos = 9'd0;
        words_left = 9'd0;
        cur_hdr = 16'd0;
        cap_seq = ppd_pkg::SEQ_NONE;
        dropped = 1'b0;
        fsender = 4'd0;
        fstrength = 8'd0;
        own_id = 4'd0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (p = 0; p < 5; p++) begin
            // write the node id while nothing is in flight
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_data <= ids[p];
            own_id = ids[p];
            @(negedge i_clk);
            i_cfg_we <= 1'b0;
            if (p == 0) queue_directed();
            added = 0;
            while (added < PHASE_BEATS) begin
                r = beats_q.size();
                if ($urandom_range(0, 9) == 0) begin
                    beats_q.push_back(random_beat());
                end else begin
                    queue_frame($urandom_range(0, 9) < 2);
                end
                added += beats_q.size() - r;
            end
            // once, let the result queue back up into the input side
            if (p == 1) begin
                while (beats_taken < 40) @(posedge i_clk);
                stall_req = stall_req + 1;
            end
            drain();
        end
        repeat (20) @(posedge i_clk);
        $display("%0d beats over 5 node ids, %0d results checked (%0d rejects)",
                 beats_taken, results_seen, rejects_seen);
        $display("left owed: %0d, mismatches: %0d", owed_results.size(), errors);
        if (errors == 0 && owed_results.size() == 0) begin
            $display("tb_port_packet_deframer OK");
        end else begin
            $display("tb_port_packet_deframer NOT OK");
        end
        $finish;
    end

endmodule

/* sim.f */
design/ppd_pkg.sv
design/ppd_ram.sv
design/ppd_front.sv
design/ppd_queue.sv
design/port_packet_deframer.sv
test/tb_port_packet_deframer.sv
